FILE: hw/rtl/hensel_exact_division_by_limb_assert.svh
`ifndef HENSEL_EXACT_DIVISION_BY_LIMB_ASSERT_SVH
`define HENSEL_EXACT_DIVISION_BY_LIMB_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HEDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define HEDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/hedl_pkg.sv
`timescale 1ns / 1ps

package hedl_pkg;

	localparam int FIELD_W       = 64;
	localparam int LIMB_BITS_DEF = 64;
	localparam int NEWT_STEPS    = 5;

	typedef logic [2:0] op_t;

	// multiplier operations: operands and writeback target
	localparam op_t OP_XL_IL  = 3'd0;  // xl * inv_low, low -> quot_low, high -> scratch
	localparam op_t OP_XH_IL  = 3'd1;  // xh * inv_low, low added to scratch
	localparam op_t OP_XL_IH  = 3'd2;  // xl * inv_high, low + scratch -> quot_high
	localparam op_t OP_Q_D    = 3'd3;  // quotient * divisor, high -> next carry
	localparam op_t OP_NEWT_A = 3'd4;  // 2 - d * inv
	localparam op_t OP_NEWT_B = 3'd5;  // inv * (2 - d * inv)
	localparam op_t OP_FIN_A  = 3'd6;  // -(high of d * inv)
	localparam op_t OP_FIN_B  = 3'd7;  // inverse high limb

	typedef struct packed {
		logic accept;
		logic start;
		logic wb;
		logic load_out;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic single;
	} stat_t;

endpackage

FILE: hw/rtl/hedl_mul.sv
`timescale 1ns / 1ps

// Sequential limb multiplier: four half-width partial products, each
// registered, then accumulated into the double-width product.
module hedl_mul #(
	parameter int LIMB_BITS = hedl_pkg::LIMB_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [LIMB_BITS-1:0]   a,
	input  logic [LIMB_BITS-1:0]   b,
	output logic                   done,
	output logic [2*LIMB_BITS-1:0] prod
);
	import hedl_pkg::*;

	localparam int H     = (LIMB_BITS + 1) / 2;
	localparam int AW    = 2 * H;
	localparam int ACC_W = 4 * H;
	localparam logic [2:0] CNT_LAST = 3'd5;

	logic [2:0]       cnt_q;
	logic             done_q;
	logic [AW-1:0]    a_q;
	logic [AW-1:0]    b_q;
	logic [AW-1:0]    pp_q;
	logic [1:0]       sh_q;
	logic [ACC_W-1:0] acc_q;

	logic [1:0]       idx;
	logic [H-1:0]     a_half;
	logic [H-1:0]     b_half;
	logic [AW-1:0]    pp_d;
	logic [ACC_W-1:0] addend;

	assign idx    = 2'(cnt_q - 3'd1);
	assign a_half = idx[0] ? a_q[AW-1:H] : a_q[H-1:0];
	assign b_half = idx[1] ? b_q[AW-1:H] : b_q[H-1:0];
	assign pp_d   = AW'(a_half) * AW'(b_half);

	always_comb begin
		case (sh_q)
			2'd0:    addend = ACC_W'(pp_q);
			2'd1:    addend = ACC_W'(pp_q) << H;
			2'd2:    addend = ACC_W'(pp_q) << AW;
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 3'd1;
			end else if (cnt_q != 3'd0) begin
				if (cnt_q == CNT_LAST) begin
					cnt_q  <= '0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= AW'(a);
			b_q   <= AW'(b);
			acc_q <= '0;
		end else begin
			if (cnt_q inside {[3'd1:3'd4]}) begin
				pp_q <= pp_d;
				sh_q <= {1'b0, idx[0]} + {1'b0, idx[1]};
			end
			if (cnt_q inside {[3'd2:CNT_LAST]}) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q[2*LIMB_BITS-1:0];

endmodule

FILE: hw/rtl/hedl_dp.sv
`timescale 1ns / 1ps

module hedl_dp #(
	parameter int LIMB_BITS = hedl_pkg::LIMB_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hedl_pkg::cmd_t                cmd,
	output hedl_pkg::stat_t               stat,
	input  logic                          cfg_wr_en,
	input  logic [hedl_pkg::FIELD_W-1:0]  cfg_wr_data,
	input  logic [hedl_pkg::FIELD_W-1:0]  limb_low,
	input  logic [hedl_pkg::FIELD_W-1:0]  limb_high,
	input  logic                          single_limb,
	input  logic                          first_item,
	input  logic                          last_item,
	output logic [hedl_pkg::FIELD_W-1:0]  quot_low,
	output logic [hedl_pkg::FIELD_W-1:0]  quot_high,
	output logic [hedl_pkg::FIELD_W-1:0]  remainder,
	output logic                          last
);
	import hedl_pkg::*;

	localparam int W = LIMB_BITS;
	localparam logic [W-1:0] TWO = W'(2);

	logic [W-1:0] div_q;
	logic [W-1:0] invl_q;
	logic [W-1:0] invh_q;
	logic [W-1:0] sum_q;     // carry + borrow, carried to the next item
	logic         borrow_q;
	logic [W-1:0] xl_q;
	logic [W-1:0] xh_q;
	logic [W-1:0] ql_q;
	logic [W-1:0] qh_q;
	logic [W-1:0] tmp_q;
	logic         single_q;
	logic         last_in_q;

	logic [FIELD_W-1:0] quot_low_q;
	logic [FIELD_W-1:0] quot_high_q;
	logic [FIELD_W-1:0] rem_q;
	logic               last_q;

	logic [W-1:0]   xl_in;
	logic [W-1:0]   xh_in;
	logic [W-1:0]   t;
	logic           gt;
	logic [W-1:0]   mul_a;
	logic [W-1:0]   mul_b;
	logic           mul_done;
	logic [2*W-1:0] prod;
	logic [W-1:0]   plo;
	logic [W-1:0]   phi;
	logic           cmp;
	logic [1:0]     inc;

	assign xl_in = limb_low[W-1:0];
	assign xh_in = limb_high[W-1:0];
	assign t     = first_item ? '0 : sum_q;
	assign gt    = t > xl_in;

	always_comb begin
		case (cmd.op)
			OP_XL_IL:  begin mul_a = xl_q;  mul_b = invl_q; end
			OP_XH_IL:  begin mul_a = xh_q;  mul_b = invl_q; end
			OP_XL_IH:  begin mul_a = xl_q;  mul_b = invh_q; end
			OP_Q_D:    begin mul_a = single_q ? ql_q : qh_q; mul_b = div_q; end
			OP_NEWT_A: begin mul_a = div_q; mul_b = invl_q; end
			OP_NEWT_B: begin mul_a = invl_q; mul_b = tmp_q; end
			OP_FIN_A:  begin mul_a = div_q; mul_b = invl_q; end
			OP_FIN_B:  begin mul_a = invl_q; mul_b = tmp_q; end
			default:   begin mul_a = '0;    mul_b = '0;    end
		endcase
	end

	hedl_mul #(
		.LIMB_BITS(LIMB_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (prod)
	);

	assign plo = prod[W-1:0];
	assign phi = prod[2*W-1:W];
	// a pair borrows one more into the carry when the low product overshoots xh
	assign cmp = !single_q && (plo > xh_q);
	assign inc = {1'b0, cmp} + {1'b0, borrow_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    <= W'(1);
			invl_q   <= W'(1);
			invh_q   <= '0;
			sum_q    <= '0;
			borrow_q <= 1'b0;
		end else if (cfg_wr_en) begin
			div_q  <= cfg_wr_data[W-1:0];
			invl_q <= cfg_wr_data[W-1:0];
		end else begin
			if (cmd.accept) begin
				borrow_q <= single_limb ? gt : (gt && xh_in == '0);
			end
			if (cmd.wb) begin
				case (cmd.op)
					OP_Q_D:    sum_q  <= phi + W'(inc);
					OP_NEWT_B: invl_q <= plo;
					OP_FIN_B:  invh_q <= plo;
					default:   ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			xl_q      <= xl_in - t;
			xh_q      <= gt ? xh_in - W'(1) : xh_in;
			single_q  <= single_limb;
			last_in_q <= last_item;
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_XL_IL: begin
					ql_q  <= plo;
					tmp_q <= phi;
				end
				OP_XH_IL:  tmp_q <= tmp_q + plo;
				OP_XL_IH:  qh_q  <= tmp_q + plo;
				OP_NEWT_A: tmp_q <= TWO - plo;
				OP_FIN_A:  tmp_q <= '0 - phi;
				default:   ;
			endcase
		end
		if (cmd.load_out) begin
			quot_low_q  <= FIELD_W'(ql_q);
			quot_high_q <= single_q ? '0 : FIELD_W'(qh_q);
			rem_q       <= last_in_q ? FIELD_W'(sum_q) : '0;
			last_q      <= last_in_q;
		end
	end

	assign stat.mul_done = mul_done;
	assign stat.single   = single_q;

	assign quot_low  = quot_low_q;
	assign quot_high = quot_high_q;
	assign remainder = rem_q;
	assign last      = last_q;

endmodule

FILE: hw/rtl/hedl_ctrl.sv
`timescale 1ns / 1ps

module hedl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output hedl_pkg::cmd_t  cmd,
	input  hedl_pkg::stat_t stat
);
	import hedl_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [2:0] ITER_LAST = 3'(NEWT_STEPS - 1);

	logic [1:0] state_q;
	op_t        op_q;
	logic [2:0] iter_q;
	logic       out_valid_q;

	logic accept;
	logic out_free;
	op_t  next_op;

	assign in_ready = (state_q == ST_IDLE) && !cfg_wr_en;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign cmd.accept   = accept;
	assign cmd.start    = (state_q == ST_START) && !cfg_wr_en;
	assign cmd.wb       = (state_q == ST_WAIT) && stat.mul_done && !cfg_wr_en;
	assign cmd.load_out = (state_q == ST_EMIT) && out_free && !cfg_wr_en;
	assign cmd.op       = op_q;

	always_comb begin
		case (op_q)
			OP_XL_IL:  next_op = stat.single ? OP_Q_D : OP_XH_IL;
			OP_XH_IL:  next_op = OP_XL_IH;
			OP_XL_IH:  next_op = OP_Q_D;
			OP_NEWT_A: next_op = OP_NEWT_B;
			OP_NEWT_B: next_op = (iter_q == ITER_LAST) ? OP_FIN_A : OP_NEWT_A;
			OP_FIN_A:  next_op = OP_FIN_B;
			default:   next_op = op_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_XL_IL;
			iter_q  <= '0;
		end else if (cfg_wr_en) begin
			// new divisor: restart the inverse from scratch
			state_q <= ST_START;
			op_q    <= OP_NEWT_A;
			iter_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_START;
						op_q    <= OP_XL_IL;
					end
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (stat.mul_done) begin
						if (op_q == OP_Q_D) begin
							state_q <= ST_EMIT;
						end else if (op_q == OP_FIN_B) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_START;
							op_q    <= next_op;
							if (op_q == OP_NEWT_B) begin
								iter_q <= iter_q + 3'd1;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/hensel_exact_division_by_limb.sv
`timescale 1ns / 1ps
// Channel     Direction  Transaction
// s_axis      in         dividend limb pair or lone tail limb, first/single flags, last
// m_axis      out        quotient limb pair, remainder on the last item, last
// cfg_wr_*    in         divisor write, starts the inverse computation
//
// A limb pair needs four limb products from acceptance to result, a lone limb two;
// each is worked out in turn on the shared half-width multiplier.
// A divisor write ties up the same multiplier for 12 products working out the
// inverse; s_axis_tready stays low meanwhile. Reset gives divisor 1.
// A finished result sits in the output register; the next item may be taken while
// it waits, and its own result is held back until m_axis takes the first one.
`include "hensel_exact_division_by_limb_assert.svh"

module hensel_exact_division_by_limb #(
	parameter int LIMB_BITS = hedl_pkg::LIMB_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [hedl_pkg::FIELD_W-1:0]    cfg_wr_data,   // divisor
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [2*hedl_pkg::FIELD_W-1:0]  s_axis_tdata,  // limb_low, limb_high
	input  logic [1:0]                      s_axis_tuser,  // single_limb, first_item
	input  logic                            s_axis_tlast,  // last_item
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [3*hedl_pkg::FIELD_W-1:0]  m_axis_tdata,  // quot_low, quot_high, remainder
	output logic                            m_axis_tlast   // last
);
	import hedl_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [FIELD_W-1:0] quot_low;
	logic [FIELD_W-1:0] quot_high;
	logic [FIELD_W-1:0] remainder;

	hedl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	hedl_dp #(
		.LIMB_BITS(LIMB_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.limb_low   (s_axis_tdata[FIELD_W-1:0]),
		.limb_high  (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
		.single_limb(s_axis_tuser[0]),
		.first_item (s_axis_tuser[1]),
		.last_item  (s_axis_tlast),
		.quot_low   (quot_low),
		.quot_high  (quot_high),
		.remainder  (remainder),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = {remainder, quot_high, quot_low};

	`HEDL_ASSERT_NOW(a_load_into_free_slot, clk, arst_n, cmd.load_out, !m_axis_tvalid || m_axis_tready, "result loaded over an unread one")
	`HEDL_ASSERT_NOW(a_wb_on_done, clk, arst_n, cmd.wb, stat.mul_done, "writeback without a finished product")
	`HEDL_ASSERT_NEXT(a_cfg_blocks_input, clk, arst_n, cfg_wr_en, !s_axis_tready, "input taken while the inverse is being built")

endmodule
